>>> sv/slb_pkg.sv
package slb_pkg;

    // value accumulator width and the width reported for a plain decimal
    localparam int          VALUE_BITS_DEF = 64;
    localparam logic [15:0] DEFAULT_WIDTH  = 16'd32;

    // literal width saturates at this value
    localparam logic [15:0] WIDTH_MAX = 16'hFFFF;

    // depth of the queues between front, back and the result port
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_MALFORMED = 2'd1,
        ST_OCTAL     = 2'd2,
        ST_OVERFLOW  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        RX_DEC = 2'd0,
        RX_BIN = 2'd1,
        RX_HEX = 2'd2,
        RX_OCT = 2'd3
    } t_radix;

    typedef enum logic [2:0] {
        PH_START = 3'd0,
        PH_WIDTH = 3'd1,
        PH_BASE  = 3'd2,
        PH_VALUE = 3'd3,
        PH_TRAIL = 3'd4,
        PH_ERROR = 3'd5
    } t_phase;

    // one input word
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_in_word;

    // one result word
    typedef struct packed {
        logic [15:0] bit_width;
        logic [63:0] number;
        t_status     status;
    } t_out_word;

    // classified character handed from front to back
    typedef struct packed {
        logic       last;
        logic       is_space;
        logic       is_apos;
        logic       is_digit;   // 0-9, a-f or A-F
        logic [3:0] dig;        // digit value when is_digit
        logic       is_base;    // one of the base letters b, d, h, o
        t_radix     base_rx;
    } t_cls;

endpackage

>>> sv/sized_literal_to_binary_core.sv
// Sized number literal parser. Characters of a literal such as 8'hA5 enter on
// i_item one per cycle (push/full); i_item.last marks the final character and
// produces exactly one result on o_result (empty/pop) with the declared width,
// the value kept in VALUE_BITS bits and a status: ok, malformed, octal
// unsupported or value overflow. A literal of decimal digits alone reports
// width 32. Leading and trailing whitespace is ignored, embedded whitespace is
// malformed, and widths above 65535 saturate. Throughput is one character per
// cycle, set by the back end's accumulator, which does one times-ten or shift
// add per character, while the result queue has room for each result. A result
// passes from its last character through the two-entry character queue, the
// back end and the two-entry result queue to o_result.
module sized_literal_to_binary_core
    import slb_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    input  t_in_word  i_item,
    output logic      full,
    output logic      empty,
    input  logic      pop,
    output t_out_word o_result
);

    t_cls      w_cls;
    logic      w_cls_empty;
    logic      w_cls_pop;
    logic      w_res_full;
    logic      w_res_push;
    t_out_word w_res;
    logic [$bits(t_out_word)-1:0] w_res_bits;

    // accept and classify characters
    slb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (i_item),
        .o_full      (full),
        .i_cls_pop   (w_cls_pop),
        .o_cls       (w_cls),
        .o_cls_empty (w_cls_empty)
    );

    // accumulate width and value, build the result
    slb_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cls       (w_cls),
        .i_cls_empty (w_cls_empty),
        .o_cls_pop   (w_cls_pop),
        .i_res_full  (w_res_full),
        .o_res_push  (w_res_push),
        .o_res       (w_res)
    );

    // hold results until popped
    slb_fifo #(
        .WIDTH ($bits(t_out_word)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_data  (w_res_bits),
        .o_empty (empty)
    );

    assign o_result = t_out_word'(w_res_bits);

endmodule

>>> sv/slb_fifo.sv
module slb_fifo
    import slb_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count,  n_count;
    logic             w_push, w_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    // advance pointers with wrap, track fill level
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // store the incoming word
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

>>> sv/slb_front.sv
module slb_front
    import slb_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_in_word i_item,
    output logic     o_full,
    input  logic     i_cls_pop,
    output t_cls     o_cls,
    output logic     o_cls_empty
);

    localparam logic [7:0] CH_APOS  = 8'h27;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_H     = 8'h68;
    localparam logic [7:0] CH_O     = 8'h6F;

    t_cls              w_cls;
    logic [$bits(t_cls)-1:0] w_cls_bits;

    // classify the character
    always_comb begin
        w_cls          = '0;
        w_cls.last     = i_item.last;
        w_cls.is_space = (i_item.ch inside {CH_SPACE, [CH_TAB:CH_CR]});
        w_cls.is_apos  = (i_item.ch == CH_APOS);
        w_cls.base_rx  = RX_DEC;
        if (i_item.ch inside {[CH_0:CH_9]}) begin
            w_cls.is_digit = 1'b1;
            w_cls.dig      = 4'(i_item.ch - CH_0);
        end else if (i_item.ch inside {[CH_LA:CH_LF]}) begin
            w_cls.is_digit = 1'b1;
            w_cls.dig      = 4'(i_item.ch - CH_LA + 8'd10);
        end else if (i_item.ch inside {[CH_UA:CH_UF]}) begin
            w_cls.is_digit = 1'b1;
            w_cls.dig      = 4'(i_item.ch - CH_UA + 8'd10);
        end
        case (i_item.ch)
            CH_B: begin
                w_cls.is_base = 1'b1;
                w_cls.base_rx = RX_BIN;
            end
            CH_D: begin
                w_cls.is_base = 1'b1;
                w_cls.base_rx = RX_DEC;
            end
            CH_H: begin
                w_cls.is_base = 1'b1;
                w_cls.base_rx = RX_HEX;
            end
            CH_O: begin
                w_cls.is_base = 1'b1;
                w_cls.base_rx = RX_OCT;
            end
            default: begin
                w_cls.is_base = 1'b0;
            end
        endcase
    end

    // hold classified words until the back takes them
    slb_fifo #(
        .WIDTH ($bits(t_cls)),
        .DEPTH (QUEUE_DEPTH)
    ) u_cls_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (w_cls),
        .o_full  (o_full),
        .i_pop   (i_cls_pop),
        .o_data  (w_cls_bits),
        .o_empty (o_cls_empty)
    );

    assign o_cls = t_cls'(w_cls_bits);

endmodule

>>> sv/slb_back.sv
module slb_back
    import slb_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cls      i_cls,
    input  logic      i_cls_empty,
    output logic      o_cls_pop,
    input  logic      i_res_full,
    output logic      o_res_push,
    output t_out_word o_res
);

    localparam int EW = VALUE_BITS + 4;

    t_phase                r_phase, n_phase, w_phase_nx;
    logic [15:0]           r_width, n_width;
    logic [VALUE_BITS-1:0] r_value, n_value;
    t_radix                r_radix, n_radix;
    logic                  r_seen,  n_seen;
    t_status               r_err,   n_err;

    logic                  w_dec_ok, w_rx_ok;
    t_radix                w_add_rx;
    logic [EW-1:0]         w_acc_ext, w_mul, w_sum;
    logic                  w_ovf;
    logic [19:0]           w_wsum;
    logic [15:0]           w_wsat;
    logic                  w_take;

    // take a word when there is one and a result, if due, has room
    assign w_take     = !i_cls_empty && (!i_cls.last || !i_res_full);
    assign o_cls_pop  = w_take;
    assign o_res_push = w_take && i_cls.last;

    // digit checks for decimal and for the current radix
    assign w_dec_ok = i_cls.is_digit && (i_cls.dig <= 4'd9);
    always_comb begin
        case (r_radix)
            RX_BIN:  w_rx_ok = i_cls.is_digit && (i_cls.dig <= 4'd1);
            RX_OCT:  w_rx_ok = i_cls.is_digit && (i_cls.dig <= 4'd7);
            RX_HEX:  w_rx_ok = i_cls.is_digit;
            default: w_rx_ok = w_dec_ok;
        endcase
    end

    // value accumulator step: shift or times ten, plus digit
    assign w_add_rx  = (r_phase == PH_VALUE) ? r_radix : RX_DEC;
    assign w_acc_ext = (r_phase == PH_START) ? '0 : EW'(r_value);
    always_comb begin
        case (w_add_rx)
            RX_BIN:  w_mul = w_acc_ext << 1;
            RX_HEX:  w_mul = w_acc_ext << 4;
            default: w_mul = (w_acc_ext << 3) + (w_acc_ext << 1);
        endcase
    end
    assign w_sum = w_mul + EW'(i_cls.dig);
    assign w_ovf = |w_sum[EW-1:VALUE_BITS];

    // width accumulator step, saturating
    assign w_wsum = ({4'b0, r_width} << 3) + ({4'b0, r_width} << 1) + 20'(i_cls.dig);
    assign w_wsat = (|w_wsum[19:16]) ? WIDTH_MAX : w_wsum[15:0];

    // next phase
    always_comb begin
        case (r_phase)
            PH_START: begin
                if (i_cls.is_space)  w_phase_nx = PH_START;
                else if (w_dec_ok)   w_phase_nx = PH_WIDTH;
                else                 w_phase_nx = PH_ERROR;
            end
            PH_WIDTH: begin
                if (i_cls.is_apos)       w_phase_nx = PH_BASE;
                else if (i_cls.is_space) w_phase_nx = PH_TRAIL;
                else if (w_dec_ok)       w_phase_nx = PH_WIDTH;
                else                     w_phase_nx = PH_ERROR;
            end
            PH_BASE: begin
                w_phase_nx = i_cls.is_base ? PH_VALUE : PH_ERROR;
            end
            PH_VALUE: begin
                if (i_cls.is_space) w_phase_nx = r_seen ? PH_TRAIL : PH_ERROR;
                else if (w_rx_ok)   w_phase_nx = PH_VALUE;
                else                w_phase_nx = PH_ERROR;
            end
            PH_TRAIL: begin
                w_phase_nx = i_cls.is_space ? PH_TRAIL : PH_ERROR;
            end
            default: begin
                w_phase_nx = PH_ERROR;
            end
        endcase
    end

    // accumulators and pending status
    always_comb begin
        n_width = r_width;
        n_value = r_value;
        n_radix = r_radix;
        n_seen  = r_seen;
        n_err   = r_err;
        if (w_phase_nx == PH_ERROR) begin
            n_err = ST_MALFORMED;
        end
        case (r_phase)
            PH_START: begin
                if (!i_cls.is_space && w_dec_ok) begin
                    n_width = 16'(i_cls.dig);
                    n_radix = RX_DEC;
                    n_value = w_sum[VALUE_BITS-1:0];
                    if (w_ovf && r_err == ST_OK) n_err = ST_OVERFLOW;
                end
            end
            PH_WIDTH: begin
                if (i_cls.is_apos) begin
                    n_value = '0;
                    n_err   = ST_OK;
                end else if (!i_cls.is_space && w_dec_ok) begin
                    n_width = w_wsat;
                    n_value = w_sum[VALUE_BITS-1:0];
                    if (w_ovf && r_err == ST_OK) n_err = ST_OVERFLOW;
                end
            end
            PH_BASE: begin
                if (i_cls.is_base) begin
                    n_radix = i_cls.base_rx;
                    if (i_cls.base_rx == RX_OCT) n_err = ST_OCTAL;
                end
            end
            PH_VALUE: begin
                if (!i_cls.is_space && w_rx_ok) begin
                    n_seen = 1'b1;
                    if (r_radix != RX_OCT) begin
                        n_value = w_sum[VALUE_BITS-1:0];
                        if (w_ovf && r_err == ST_OK) n_err = ST_OVERFLOW;
                    end
                end
            end
            default: begin
                n_seen = r_seen;
            end
        endcase
    end

    // result from the state after this character
    always_comb begin
        o_res.bit_width = '0;
        o_res.number    = '0;
        o_res.status    = ST_MALFORMED;
        if (w_phase_nx == PH_WIDTH || (w_phase_nx == PH_TRAIL && !n_seen)) begin
            o_res.bit_width = DEFAULT_WIDTH;
            o_res.number    = 64'(n_value);
            o_res.status    = n_err;
        end else if ((w_phase_nx == PH_VALUE || w_phase_nx == PH_TRAIL) && n_seen) begin
            o_res.bit_width = n_width;
            o_res.number    = (n_err == ST_OCTAL) ? '0 : 64'(n_value);
            o_res.status    = n_err;
        end
    end

    // drop back to the start state after the last character
    assign n_phase = i_cls.last ? PH_START : w_phase_nx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_width <= '0;
            r_value <= '0;
            r_radix <= RX_DEC;
            r_seen  <= 1'b0;
            r_err   <= ST_OK;
        end else if (w_take) begin
            r_phase <= n_phase;
            if (i_cls.last) begin
                r_width <= '0;
                r_value <= '0;
                r_radix <= RX_DEC;
                r_seen  <= 1'b0;
                r_err   <= ST_OK;
            end else begin
                r_width <= n_width;
                r_value <= n_value;
                r_radix <= n_radix;
                r_seen  <= n_seen;
                r_err   <= n_err;
            end
        end
    end

endmodule
